// ===== rtl/owtr_pkg.sv =====
package owtr_pkg;

  localparam int TIMER_BITS = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 20;
  localparam int TIME_BITS = 10;
  localparam int NUM_REGS = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RESET_LOW      = 3'd0,
    REG_PRESENCE_WAIT  = 3'd1,
    REG_RESET_TAIL     = 3'd2,
    REG_SLOT           = 3'd3,
    REG_ZERO_LOW       = 3'd4,
    REG_SHORT_LOW      = 3'd5,
    REG_READ_SAMPLE    = 3'd6,
    REG_CONV_WAIT      = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_RESET   = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_ACQUIRE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WAIT  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_SLOT_WR  = 3'd4,
    PH_SLOT_RD  = 3'd5,
    PH_CONV     = 3'd6
  } phase_t;

  localparam logic [7:0] ROM_SKIP      = 8'hCC;
  localparam logic [7:0] TEMP_CONVERT  = 8'h44;
  localparam logic [7:0] READ_SCRATCH  = 8'hBE;
  localparam logic [3:0] LAST_STEP     = 4'd8;
  localparam logic [3:0] LOW_BYTE_STEP = 4'd7;

  typedef struct packed {
    logic       tick;
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence;
    logic [15:0] read_data;
  } result_t;

  typedef struct packed {
    phase_t                  phase;
    logic [TIMER_BITS-1:0]   time_count;
    logic [2:0]              bit_index;
    logic [3:0]              sequence_step;
    logic [7:0]              shift_byte;
    logic [15:0]             result_word;
    logic                    presence_flag;
    logic [1:0]              held_opcode;
  } state_t;

  typedef struct packed {
    logic                      we;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

  function automatic logic [CFG_DATA_BITS-1:0] reg_init(input logic [CFG_INDEX_BITS-1:0] idx);
    logic [CFG_DATA_BITS-1:0] v;
    case (idx)
      REG_RESET_LOW:     v = 20'd480;
      REG_PRESENCE_WAIT: v = 20'd70;
      REG_RESET_TAIL:    v = 20'd410;
      REG_SLOT:          v = 20'd70;
      REG_ZERO_LOW:      v = 20'd60;
      REG_SHORT_LOW:     v = 20'd6;
      REG_READ_SAMPLE:   v = 20'd15;
      default:           v = 20'd10000;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] reg_mask(input logic [CFG_INDEX_BITS-1:0] idx);
    logic [CFG_DATA_BITS-1:0] v;
    case (idx)
      REG_CONV_WAIT: v = {CFG_DATA_BITS{1'b1}};
      default:       v = CFG_DATA_BITS'({TIME_BITS{1'b1}});
    endcase
    return v;
  endfunction

  // acquisition sequence, steps past the end act as the last read
  function automatic action_t seq_act(input logic [3:0] step);
    action_t a;
    case (step)
      4'd0:    a = ACT_RESET;
      4'd1:    a = ACT_WRITE;
      4'd2:    a = ACT_WRITE;
      4'd3:    a = ACT_WAIT;
      4'd4:    a = ACT_RESET;
      4'd5:    a = ACT_WRITE;
      4'd6:    a = ACT_WRITE;
      default: a = ACT_READ;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd1:    b = ROM_SKIP;
      4'd2:    b = TEMP_CONVERT;
      4'd5:    b = ROM_SKIP;
      4'd6:    b = READ_SCRATCH;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/owtr_ifs.sv =====
interface owtr_in_if;
  logic       valid;
  logic       ready;
  logic       tick;
  logic       cmd_valid;
  logic [1:0] opcode;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, tick, cmd_valid, opcode, write_data, line_level,
                  input ready);
  modport sink (input valid, tick, cmd_valid, opcode, write_data, line_level,
                output ready);
endinterface

interface owtr_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic        presence;
  logic [15:0] read_data;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                  input ready);
  modport sink (input valid, drive_low, busy_res, done_res, presence, read_data,
                output ready);
endinterface

interface owtr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [owtr_pkg::CFG_INDEX_BITS-1:0] index;
  logic [owtr_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/owtr_core.sv =====
module owtr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  owtr_pkg::item_t      item,
  input  owtr_pkg::cfg_write_t cfg_wr,
  output owtr_pkg::result_t    result
);

  localparam logic [owtr_pkg::TIMER_BITS-1:0] TMAX = {owtr_pkg::TIMER_BITS{1'b1}};

  logic [owtr_pkg::CFG_DATA_BITS-1:0] regs [owtr_pkg::NUM_REGS];
  owtr_pkg::state_t state;
  owtr_pkg::state_t state_next;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < owtr_pkg::NUM_REGS; i++) begin
        regs[i] <= owtr_pkg::reg_init(owtr_pkg::CFG_INDEX_BITS'(i));
      end
    end else if (cfg_wr.we) begin
      regs[cfg_wr.index] <= cfg_wr.data & owtr_pkg::reg_mask(cfg_wr.index);
    end
  end

  function automatic owtr_pkg::state_t start_step(input owtr_pkg::state_t s,
                                                  input logic [7:0] wd);
    owtr_pkg::state_t r;
    owtr_pkg::action_t act;
    logic [7:0] byte_val;
    r = s;
    case (s.held_opcode)
      owtr_pkg::OP_RESET: begin
        act = owtr_pkg::ACT_RESET;
        byte_val = 8'h00;
      end
      owtr_pkg::OP_WRITE: begin
        act = owtr_pkg::ACT_WRITE;
        byte_val = wd;
      end
      owtr_pkg::OP_READ: begin
        act = owtr_pkg::ACT_READ;
        byte_val = 8'h00;
      end
      default: begin
        act = owtr_pkg::seq_act(s.sequence_step);
        byte_val = owtr_pkg::seq_byte(s.sequence_step);
      end
    endcase
    r.time_count = '0;
    r.bit_index = 3'd0;
    case (act)
      owtr_pkg::ACT_RESET: r.phase = owtr_pkg::PH_RST_LOW;
      owtr_pkg::ACT_WRITE: begin
        r.phase = owtr_pkg::PH_SLOT_WR;
        r.shift_byte = byte_val;
      end
      owtr_pkg::ACT_READ: begin
        r.phase = owtr_pkg::PH_SLOT_RD;
        r.shift_byte = 8'h00;
      end
      default: r.phase = owtr_pkg::PH_CONV;
    endcase
    return r;
  endfunction

  logic [owtr_pkg::TIMER_BITS-1:0] n;
  logic [owtr_pkg::TIMER_BITS-1:0] lim;
  logic [owtr_pkg::TIMER_BITS-1:0] rs;
  logic [owtr_pkg::TIMER_BITS-1:0] low_time;
  logic sat;
  logic done;
  logic drive;

  always_comb begin
    state_next = state;
    done = 1'b0;
    n = '0;
    lim = '0;
    rs = '0;
    sat = 1'b0;

    if (state_next.phase == owtr_pkg::PH_IDLE && item.cmd_valid) begin
      state_next.held_opcode = item.opcode;
      state_next.sequence_step = 4'd0;
      state_next = start_step(state_next, item.write_data);
    end

    if (item.tick && state_next.phase != owtr_pkg::PH_IDLE) begin
      n = (state_next.time_count != TMAX) ? state_next.time_count + 1'b1 : TMAX;
      sat = (n == TMAX);
      case (state_next.phase)
        owtr_pkg::PH_RST_LOW:  lim = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_RESET_LOW]);
        owtr_pkg::PH_RST_WAIT: lim = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_PRESENCE_WAIT]);
        owtr_pkg::PH_RST_TAIL: lim = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_RESET_TAIL]);
        owtr_pkg::PH_CONV:     lim = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_CONV_WAIT]);
        default: begin
          lim = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_SLOT]);
          if (lim == '0) begin
            lim = owtr_pkg::TIMER_BITS'(1);
          end
        end
      endcase

      if (state_next.phase == owtr_pkg::PH_SLOT_RD) begin
        rs = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_READ_SAMPLE]);
        if (rs == '0 || rs > lim) begin
          rs = lim;
        end
        if (n == rs || (sat && n < rs)) begin
          state_next.shift_byte[state_next.bit_index] =
            state_next.shift_byte[state_next.bit_index] | item.line_level;
        end
      end

      if (n >= lim || sat) begin
        case (state_next.phase)
          owtr_pkg::PH_RST_LOW: begin
            state_next.phase = owtr_pkg::PH_RST_WAIT;
            state_next.time_count = '0;
          end
          owtr_pkg::PH_RST_WAIT: begin
            state_next.presence_flag = ~item.line_level;
            state_next.phase = owtr_pkg::PH_RST_TAIL;
            state_next.time_count = '0;
          end
          default: begin
            if (state_next.phase == owtr_pkg::PH_RST_TAIL ||
                state_next.phase == owtr_pkg::PH_CONV ||
                state_next.bit_index == 3'd7) begin
              // byte read finishes into the result word
              if (state_next.phase == owtr_pkg::PH_SLOT_RD) begin
                if (state_next.held_opcode == owtr_pkg::OP_READ ||
                    state_next.sequence_step == owtr_pkg::LOW_BYTE_STEP) begin
                  state_next.result_word = {8'h00, state_next.shift_byte};
                end else begin
                  state_next.result_word = {state_next.shift_byte,
                                            state_next.result_word[7:0]};
                end
              end
              if (state_next.held_opcode != owtr_pkg::OP_ACQUIRE ||
                  state_next.sequence_step >= owtr_pkg::LAST_STEP) begin
                state_next.phase = owtr_pkg::PH_IDLE;
                state_next.time_count = '0;
                state_next.sequence_step = 4'd0;
                done = 1'b1;
              end else begin
                state_next.sequence_step = state_next.sequence_step + 4'd1;
                state_next = start_step(state_next, 8'h00);
              end
            end else begin
              state_next.bit_index = state_next.bit_index + 3'd1;
              state_next.time_count = '0;
            end
          end
        endcase
      end else begin
        state_next.time_count = n;
      end
    end
  end

  always_comb begin
    low_time = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_SHORT_LOW]);
    if (state_next.phase == owtr_pkg::PH_SLOT_WR &&
        !state_next.shift_byte[state_next.bit_index]) begin
      low_time = owtr_pkg::TIMER_BITS'(regs[owtr_pkg::REG_ZERO_LOW]);
    end
    case (state_next.phase)
      owtr_pkg::PH_RST_LOW: drive = 1'b1;
      owtr_pkg::PH_SLOT_WR,
      owtr_pkg::PH_SLOT_RD: drive = state_next.time_count < low_time;
      default:              drive = 1'b0;
    endcase
  end

  assign result.drive_low = drive;
  assign result.busy_res  = state_next.phase != owtr_pkg::PH_IDLE;
  assign result.done_res  = done;
  assign result.presence  = state_next.presence_flag;
  assign result.read_data = state_next.result_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= owtr_pkg::PH_IDLE;
      state.time_count    <= '0;
      state.bit_index     <= 3'd0;
      state.sequence_step <= 4'd0;
      state.shift_byte    <= 8'h00;
      state.result_word   <= 16'h0000;
      state.presence_flag <= 1'b0;
      state.held_opcode   <= 2'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/onewire_master_temp_reader.sv =====
// channel  modport  transaction
// req      sink     tick, cmd_valid, opcode, write_data, line_level
// rsp      source   drive_low, busy_res, done_res, presence, read_data
// cfg      sink     index, data (timing register write, always ready)
//
// the bus state advances in one pass and the result is
// registered at the accepting edge, offered on rsp from the next cycle
// a new item is taken every cycle while the output register is empty or drained
// rst is synchronous and restores idle state and default timing registers
// stalls on rsp hold req off; nothing is dropped or repeated
module onewire_master_temp_reader (
  input  logic       clk,
  input  logic       rst,
  owtr_in_if.sink    req,
  owtr_out_if.source rsp,
  owtr_cfg_if.sink   cfg
);

  logic                 accept;
  owtr_pkg::item_t      item;
  owtr_pkg::cfg_write_t cfg_wr;
  owtr_pkg::result_t    result;
  owtr_pkg::result_t    result_q;
  logic                 out_valid;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign item.tick       = req.tick;
  assign item.cmd_valid  = req.cmd_valid;
  assign item.opcode     = req.opcode;
  assign item.write_data = req.write_data;
  assign item.line_level = req.line_level;

  assign cfg_wr.we    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  owtr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg_wr (cfg_wr),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.drive_low = result_q.drive_low;
  assign rsp.busy_res  = result_q.busy_res;
  assign rsp.done_res  = result_q.done_res;
  assign rsp.presence  = result_q.presence;
  assign rsp.read_data = result_q.read_data;

endmodule

// ===== verif/onewire_master_temp_reader_tb.sv =====
module onewire_master_temp_reader_tb;
  import owtr_pkg::*;

  typedef enum int {TM_ONES, TM_SMALL, TM_ZERO, TM_LATE, TM_MAX} timing_set_t;

  typedef struct {
    logic    known;
    logic    settle;
    item_t   it;
    result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 14;
  localparam int DIR_AT_DEFAULT = 3;
  localparam int PHASE_ITEMS = 110;
  localparam int MAX_PHASE_ITEMS = 20;
  localparam int PLAN_LEN = 10;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [CFG_DATA_BITS-1:0] TIME_MASK = CFG_DATA_BITS'({TIME_BITS{1'b1}});

  logic clk;
  logic rst;

  owtr_in_if  req_if ();
  owtr_out_if rsp_if ();
  owtr_cfg_if cfg_if ();

  onewire_master_temp_reader u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // bus master copy: timing registers and sequencing state
  logic [CFG_DATA_BITS-1:0] bus_timing [NUM_REGS];
  phase_t                   bus_phase;
  logic [TIMER_BITS-1:0]    elapsed;
  logic [2:0]               bit_pos;
  logic [3:0]               acq_step;
  logic [7:0]               shreg;
  logic [15:0]              word;
  logic                     seen_presence;
  opcode_t                  cur_op;

  result_t  pending_results [$];
  dir_row_t dir_rows [DIR_ROWS];
  timing_set_t phase_plan [PLAN_LEN] = '{TM_ONES, TM_SMALL, TM_ZERO, TM_SMALL, TM_LATE,
                                         TM_MAX, TM_SMALL, TM_LATE, TM_ZERO, TM_SMALL};

  int  n_errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_done = 0;
  int  n_acq = 0;
  int  n_settings = 0;
  bit  calm_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic action_t acq_action(input logic [3:0] s);
    case (s)
      4'd0, 4'd4:             return ACT_RESET;
      4'd1, 4'd2, 4'd5, 4'd6: return ACT_WRITE;
      4'd3:                   return ACT_WAIT;
      default:                return ACT_READ;
    endcase
  endfunction

  function automatic logic [7:0] acq_byte(input logic [3:0] s);
    case (s)
      4'd1, 4'd5: return ROM_SKIP;
      4'd2:       return TEMP_CONVERT;
      4'd6:       return READ_SCRATCH;
      default:    return 8'h00;
    endcase
  endfunction

  task automatic clear_model();
    bus_timing[REG_RESET_LOW]     = 20'd480;
    bus_timing[REG_PRESENCE_WAIT] = 20'd70;
    bus_timing[REG_RESET_TAIL]    = 20'd410;
    bus_timing[REG_SLOT]          = 20'd70;
    bus_timing[REG_ZERO_LOW]      = 20'd60;
    bus_timing[REG_SHORT_LOW]     = 20'd6;
    bus_timing[REG_READ_SAMPLE]   = 20'd15;
    bus_timing[REG_CONV_WAIT]     = 20'd10000;
    bus_phase = PH_IDLE;
    elapsed = '0;
    bit_pos = '0;
    acq_step = '0;
    shreg = '0;
    word = '0;
    seen_presence = 1'b0;
    cur_op = OP_RESET;
  endtask

  task automatic start_action(input action_t act, input logic [7:0] b);
    elapsed = '0;
    bit_pos = '0;
    case (act)
      ACT_RESET: bus_phase = PH_RST_LOW;
      ACT_WRITE: begin
        shreg = b;
        bus_phase = PH_SLOT_WR;
      end
      ACT_READ: begin
        shreg = '0;
        bus_phase = PH_SLOT_RD;
      end
      default: bus_phase = PH_CONV;
    endcase
  endtask

  task automatic start_step(input logic [7:0] wd);
    case (cur_op)
      OP_RESET: start_action(ACT_RESET, 8'h00);
      OP_WRITE: start_action(ACT_WRITE, wd);
      OP_READ:  start_action(ACT_READ, 8'h00);
      default:  start_action(acq_action(acq_step), acq_byte(acq_step));
    endcase
  endtask

  task automatic end_action(inout logic done);
    if (cur_op != OP_ACQUIRE || acq_step >= LAST_STEP) begin
      if (cur_op == OP_ACQUIRE) n_acq++;
      bus_phase = PH_IDLE;
      elapsed = '0;
      acq_step = '0;
      done = 1'b1;
    end else begin
      acq_step++;
      start_step(8'h00);
    end
  endtask

  task automatic latch_read_byte();
    if (cur_op == OP_READ || acq_step == LOW_BYTE_STEP) begin
      word = {8'h00, shreg};
    end else begin
      word = {shreg, word[7:0]};
    end
  endtask

  task automatic predict_bus(input item_t it, output result_t r);
    logic                  done;
    logic                  drive;
    logic                  sat;
    logic [TIMER_BITS-1:0] n;
    logic [TIMER_BITS-1:0] lim;
    logic [TIMER_BITS-1:0] rs;
    logic [TIMER_BITS-1:0] low;
    done = 1'b0;
    drive = 1'b0;
    if (bus_phase == PH_IDLE && it.cmd_valid) begin
      cur_op = opcode_t'(it.opcode);
      acq_step = '0;
      start_step(it.write_data);
    end
    if (it.tick && bus_phase != PH_IDLE) begin
      n = (elapsed < TIMER_MAX) ? elapsed + 1'b1 : TIMER_MAX;
      sat = (n == TIMER_MAX);
      case (bus_phase)
        PH_RST_LOW:  lim = bus_timing[REG_RESET_LOW];
        PH_RST_WAIT: lim = bus_timing[REG_PRESENCE_WAIT];
        PH_RST_TAIL: lim = bus_timing[REG_RESET_TAIL];
        PH_CONV:     lim = bus_timing[REG_CONV_WAIT];
        default:     lim = (bus_timing[REG_SLOT] != '0) ? bus_timing[REG_SLOT] : 20'd1;
      endcase
      if (bus_phase == PH_SLOT_RD) begin
        rs = bus_timing[REG_READ_SAMPLE];
        if (rs == '0 || rs > lim) rs = lim;
        if (n == rs || (sat && n < rs)) shreg[bit_pos] = shreg[bit_pos] | it.line_level;
      end
      if (n >= lim || sat) begin
        case (bus_phase)
          PH_RST_LOW: begin
            bus_phase = PH_RST_WAIT;
            elapsed = '0;
          end
          PH_RST_WAIT: begin
            seen_presence = !it.line_level;
            bus_phase = PH_RST_TAIL;
            elapsed = '0;
          end
          PH_RST_TAIL, PH_CONV: end_action(done);
          default: begin
            if (bit_pos == 3'd7) begin
              if (bus_phase == PH_SLOT_RD) latch_read_byte();
              end_action(done);
            end else begin
              bit_pos++;
              elapsed = '0;
            end
          end
        endcase
      end else begin
        elapsed = n;
      end
    end
    case (bus_phase)
      PH_RST_LOW: drive = 1'b1;
      PH_SLOT_WR: begin
        low = shreg[bit_pos] ? bus_timing[REG_SHORT_LOW] : bus_timing[REG_ZERO_LOW];
        drive = elapsed < low;
      end
      PH_SLOT_RD: drive = elapsed < bus_timing[REG_SHORT_LOW];
      default:    drive = 1'b0;
    endcase
    if (done) n_done++;
    r = '{drive_low: drive, busy_res: (bus_phase != PH_IDLE), done_res: done,
          presence: seen_presence, read_data: word};
  endtask

  function automatic int pick_pause(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic dir_row_t dir_row(input logic known, input logic settle, input logic tick,
                                       input logic cv, input opcode_t op, input logic [7:0] wd,
                                       input logic line, input result_t want);
    dir_row_t d;
    d.known = known;
    d.settle = settle;
    d.it = '{tick: tick, cmd_valid: cv, opcode: op, write_data: wd, line_level: line};
    d.want = want;
    return d;
  endfunction

  function automatic item_t rand_item(input timing_set_t kind);
    item_t it;
    int    r;
    it.tick = (kind == TM_MAX) ? 1'b1 : ($urandom_range(0, 99) < 85);
    it.cmd_valid = (bus_phase == PH_IDLE) ? ($urandom_range(0, 9) < 7)
                                          : ($urandom_range(0, 9) < 3);
    r = $urandom_range(0, 9);
    if (kind == TM_MAX) it.opcode = 2'($urandom_range(0, 2));
    else if (r < 4)     it.opcode = OP_ACQUIRE;
    else if (r < 6)     it.opcode = OP_WRITE;
    else if (r < 8)     it.opcode = OP_READ;
    else                it.opcode = OP_RESET;
    it.write_data = 8'($urandom_range(0, 255));
    it.line_level = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t r;
    int      gap;
    gap = pick_pause(calm_req);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.tick       <= it.tick;
    req_if.cmd_valid  <= it.cmd_valid;
    req_if.opcode     <= it.opcode;
    req_if.write_data <= it.write_data;
    req_if.line_level <= it.line_level;
    do @(posedge clk); while (!req_if.ready);
    predict_bus(it, r);
    pending_results.push_back(typed ? want : r);
    n_items++;
  endtask

  task automatic wait_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic drain();
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic finish_bus();
    while (bus_phase != PH_IDLE) send_item(rand_item(TM_MAX), 1'b0, '0);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    bus_timing[idx] = (idx == REG_CONV_WAIT) ? val : (val & TIME_MASK);
  endtask

  task automatic program_timing(input timing_set_t kind);
    logic [CFG_DATA_BITS-1:0] v [NUM_REGS];
    int                       slot;
    int                       i;
    slot = $urandom_range(2, 6);
    for (i = 0; i < NUM_REGS; i++) v[i] = '0;
    case (kind)
      TM_ONES: begin
        for (i = 0; i < NUM_REGS; i++) v[i] = 20'd1;
        v[REG_SLOT] = 20'd2;
      end
      TM_SMALL: begin
        v[REG_RESET_LOW]     = CFG_DATA_BITS'($urandom_range(1, 4));
        v[REG_PRESENCE_WAIT] = CFG_DATA_BITS'($urandom_range(1, 4));
        v[REG_RESET_TAIL]    = CFG_DATA_BITS'($urandom_range(1, 4));
        v[REG_SLOT]          = CFG_DATA_BITS'(slot);
        v[REG_ZERO_LOW]      = CFG_DATA_BITS'($urandom_range(0, slot));
        v[REG_SHORT_LOW]     = CFG_DATA_BITS'($urandom_range(1, slot));
        v[REG_READ_SAMPLE]   = CFG_DATA_BITS'($urandom_range(1, slot));
        v[REG_CONV_WAIT]     = CFG_DATA_BITS'($urandom_range(1, 12));
        // junk above the 10-bit timing fields
        for (i = 0; i < NUM_REGS - 1; i++) begin
          if ($urandom_range(0, 1)) begin
            v[i][CFG_DATA_BITS-1:TIME_BITS] = (CFG_DATA_BITS - TIME_BITS)'($urandom_range(0, 1023));
          end
        end
      end
      TM_LATE: begin
        slot = $urandom_range(2, 4);
        v[REG_RESET_LOW]     = CFG_DATA_BITS'($urandom_range(0, 2));
        v[REG_PRESENCE_WAIT] = CFG_DATA_BITS'($urandom_range(0, 2));
        v[REG_RESET_TAIL]    = CFG_DATA_BITS'($urandom_range(0, 2));
        v[REG_SLOT]          = CFG_DATA_BITS'(slot);
        v[REG_ZERO_LOW]      = CFG_DATA_BITS'($urandom_range(0, 8));
        v[REG_SHORT_LOW]     = CFG_DATA_BITS'($urandom_range(0, 8));
        case ($urandom_range(0, 2))
          0:       v[REG_READ_SAMPLE] = 20'd0;
          1:       v[REG_READ_SAMPLE] = CFG_DATA_BITS'(slot + $urandom_range(1, 4));
          default: v[REG_READ_SAMPLE] = 20'd1023;
        endcase
        v[REG_CONV_WAIT]     = CFG_DATA_BITS'($urandom_range(0, 3));
      end
      TM_MAX: begin
        // top low and sample times inside short slots, top conversion wait unused
        for (i = 0; i < NUM_REGS; i++) v[i] = 20'd1023;
        v[REG_RESET_LOW]     = CFG_DATA_BITS'($urandom_range(1, 3));
        v[REG_PRESENCE_WAIT] = CFG_DATA_BITS'($urandom_range(1, 3));
        v[REG_RESET_TAIL]    = CFG_DATA_BITS'($urandom_range(1, 3));
        v[REG_SLOT]          = CFG_DATA_BITS'(slot);
        v[REG_CONV_WAIT]     = 20'hFFFFF;
      end
      default: ;
    endcase
    for (i = 0; i < NUM_REGS; i++) begin
      write_reg(reg_index_t'(i), v[i]);
      if ($urandom_range(0, 3) == 0) begin
        cfg_if.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    n_errors++;
    if (n_errors <= 40) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_rsp
    result_t got;
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{drive_low: rsp_if.drive_low, busy_res: rsp_if.busy_res,
              done_res: rsp_if.done_res, presence: rsp_if.presence,
              read_data: rsp_if.read_data};
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 40) begin
          $display("%0t: unexpected transaction, expected none, got %0h", $time, got);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.drive_low !== want.drive_low)
          note_mismatch("drive_low", 16'(want.drive_low), 16'(got.drive_low));
        if (got.busy_res !== want.busy_res)
          note_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        if (got.done_res !== want.done_res)
          note_mismatch("done_res", 16'(want.done_res), 16'(got.done_res));
        if (got.presence !== want.presence)
          note_mismatch("presence", 16'(want.presence), 16'(got.presence));
        if (got.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, got.read_data);
      end
    end
  end

  initial begin : rsp_pacer
    int run_len;
    int stall_len;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 30);
      rsp_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_pause(1'b0);
      if (stall_len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin
    #50000000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    result_t idle_res;
    result_t rst_start;
    int      i;
    int      k;
    int      n_phase;
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.tick       <= 1'b0;
    req_if.cmd_valid  <= 1'b0;
    req_if.opcode     <= OP_RESET;
    req_if.write_data <= 8'h00;
    req_if.line_level <= 1'b1;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_RESET_LOW;
    cfg_if.data       <= '0;
    clear_model();

    idle_res  = '{drive_low: 1'b0, busy_res: 1'b0, done_res: 1'b0, presence: 1'b0,
                  read_data: 16'h0000};
    rst_start = '{drive_low: 1'b1, busy_res: 1'b1, done_res: 1'b0, presence: 1'b0,
                  read_data: 16'h0000};
    dir_rows[0]  = dir_row(1'b1, 1'b0, 1'b1, 1'b0, OP_RESET,   8'h00, 1'b0, idle_res);
    dir_rows[1]  = dir_row(1'b1, 1'b0, 1'b0, 1'b0, OP_ACQUIRE, 8'hFF, 1'b1, idle_res);
    dir_rows[2]  = dir_row(1'b1, 1'b0, 1'b1, 1'b0, OP_WRITE,   8'hFF, 1'b1, idle_res);
    dir_rows[3]  = dir_row(1'b1, 1'b0, 1'b0, 1'b1, OP_RESET,   8'h00, 1'b1, rst_start);
    // commands offered while busy are dropped
    dir_rows[4]  = dir_row(1'b0, 1'b0, 1'b1, 1'b1, OP_WRITE,   8'hFF, 1'b0, '0);
    dir_rows[5]  = dir_row(1'b0, 1'b0, 1'b1, 1'b0, OP_READ,    8'h00, 1'b0, '0);
    dir_rows[6]  = dir_row(1'b0, 1'b0, 1'b1, 1'b1, OP_READ,    8'h00, 1'b1, '0);
    dir_rows[7]  = dir_row(1'b0, 1'b1, 1'b1, 1'b1, OP_WRITE,   8'h00, 1'b1, '0);
    dir_rows[8]  = dir_row(1'b0, 1'b1, 1'b1, 1'b1, OP_WRITE,   8'hFF, 1'b0, '0);
    dir_rows[9]  = dir_row(1'b0, 1'b0, 1'b0, 1'b1, OP_READ,    8'h00, 1'b1, '0);
    dir_rows[10] = dir_row(1'b0, 1'b1, 1'b1, 1'b0, OP_ACQUIRE, 8'hFF, 1'b1, '0);
    dir_rows[11] = dir_row(1'b0, 1'b1, 1'b1, 1'b1, OP_READ,    8'h55, 1'b0, '0);
    // reset started with the line high; the bus then settles on random line levels
    dir_rows[12] = dir_row(1'b0, 1'b1, 1'b1, 1'b1, OP_RESET,   8'hAA, 1'b1, '0);
    dir_rows[13] = dir_row(1'b0, 1'b1, 1'b1, 1'b1, OP_ACQUIRE, 8'h00, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);
      if (dir_rows[i].settle) finish_bus();
      if (i == DIR_AT_DEFAULT - 1) begin
        drain();
        program_timing(TM_ONES);
      end
    end

    for (k = 0; k < PLAN_LEN; k++) begin
      finish_bus();
      drain();
      program_timing(phase_plan[k]);
      n_phase = (phase_plan[k] == TM_MAX) ? MAX_PHASE_ITEMS : PHASE_ITEMS;
      for (i = 0; i < n_phase; i++) begin
        if ($urandom_range(0, 79) == 0) calm_req = !calm_req;
        send_item(rand_item(phase_plan[k]), 1'b0, '0);
        if ((k == 1 && i == 50) || $urandom_range(0, 149) == 0) wait_results();
      end
    end

    finish_bus();
    wait_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d bus transactions and %0d checked results over %0d timing settings",
             n_items, n_results, n_settings);
    $display("%0d commands completed, %0d of them temperature acquisitions", n_done, n_acq);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
